### hw/rtl/csrgb_pkg.sv
// Shared constants for the crop, downscale and RGB565-to-RGB888 block.
package csrgb_pkg;

	localparam int COORD_BITS_DEF = 12;
	localparam int CFG_INDEX_BITS = 3;

	localparam logic [CFG_INDEX_BITS-1:0] REG_SOURCE_WIDTH  = 3'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_SOURCE_HEIGHT = 3'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW_LEFT   = 3'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW_TOP    = 3'd3;
	localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW_SIZE   = 3'd4;
	localparam logic [CFG_INDEX_BITS-1:0] REG_OUTPUT_SIZE   = 3'd5;

	localparam int RST_SOURCE_WIDTH  = 320;
	localparam int RST_SOURCE_HEIGHT = 240;
	localparam int RST_WINDOW_LEFT   = 40;
	localparam int RST_WINDOW_TOP    = 0;
	localparam int RST_WINDOW_SIZE   = 240;
	localparam int RST_OUTPUT_SIZE   = 192;

	localparam int RED_MASK   = 'h1F;
	localparam int GREEN_MASK = 'h3F;

endpackage

### hw/rtl/csrgb_div.sv
// Restoring divider, one quotient bit per cycle, for the scale step and remainder.
module csrgb_div #(
	parameter int W = csrgb_pkg::COORD_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic [W-1:0]           dividend,
	input  logic [W-1:0]           divisor,
	output logic [W-1:0]           quotient,
	output logic [W-1:0]           remainder
);
	import csrgb_pkg::*;

	localparam int CNT_W = $clog2(W + 1);

	logic [W-1:0]     rem_q;
	logic [W-1:0]     quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic [W:0]       shifted;
	logic [W+1:0]     diff;
	logic             neg;

	always_comb begin
		shifted = {rem_q, quo_q[W-1]};
		diff    = {1'b0, shifted} - {2'b00, divisor};
		neg     = diff[W+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (cnt_q != '0) begin
			rem_q <= neg ? shifted[W-1:0] : diff[W-1:0];
			quo_q <= {quo_q[W-2:0], ~neg};
		end
	end

	assign busy      = (cnt_q != '0);
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

### hw/rtl/crop_scale_rgb565_to_rgb888.sv
// Top level: square crop, nearest-neighbour downscale and RGB565 to RGB888 widening.
//
//   channel  handshake              payload
//   in       in_valid / in_stall    pixel, frame_start
//   out      out_valid / out_stall  red, green, blue, line_end, frame_end
//   cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One pixel a cycle unless a stall holds it: input register, then counter and select logic
// into the result register; pixels outside the grid yield no result.
// After reset and after every register write the scale step is divided out,
// one quotient bit a cycle, while in_stall is held high.
// Reset clears all counters; a held out_stall stalls the input once input and result registers are full.
module crop_scale_rgb565_to_rgb888 #(
	parameter int COORD_BITS = csrgb_pkg::COORD_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [15:0]                          pixel,
	input  logic                                 frame_start,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [7:0]                           red,
	output logic [7:0]                           green,
	output logic [7:0]                           blue,
	output logic                                 line_end,
	output logic                                 frame_end,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [csrgb_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [COORD_BITS-1:0]                cfg_data
);
	import csrgb_pkg::*;

	localparam int W = COORD_BITS;

	typedef struct packed {
		logic [W-1:0] off;
		logic [W-1:0] rem;
	} axis_t;

	function automatic axis_t advance(input axis_t cur, input logic [W-1:0] q,
			input logic [W-1:0] r, input logic [W-1:0] d);
		axis_t      res;
		logic [W:0] nr;
		logic [W:0] no;
		nr = {1'b0, cur.rem} + {1'b0, r};
		no = {1'b0, cur.off} + {1'b0, q};
		if (nr >= {1'b0, d}) begin
			nr = nr - {1'b0, d};
			no = no + 1'b1;
		end
		res.off = no[W-1:0];
		res.rem = nr[W-1:0];
		return res;
	endfunction

	// configuration registers
	logic [W-1:0] src_width_q, src_height_q, win_left_q, win_top_q, win_size_q, out_size_q;
	logic         cfg_we;
	logic         start_q;
	logic         div_busy;
	logic [W-1:0] step_q, step_r, dsize;
	logic         busy;

	// frame state
	logic [W-1:0] src_col_q, src_row_q, out_col_q, out_row_q;
	axis_t        col_axis_q, row_axis_q;

	// input stage
	logic         valid_s1;
	logic [15:0]  pixel_s1;
	logic         fs_s1;

	logic         out_free, s1_go;
	logic [W-1:0] e_src_col, e_src_row, e_out_col, e_out_row;
	axis_t        e_col_axis, e_row_axis;
	logic [W-1:0] n_src_col, n_src_row, n_out_col, n_out_row;
	axis_t        n_col_axis, n_row_axis;
	logic         row_hit, col_hit, hit, le, fe;
	logic         valid_q;

	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid & cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_width_q  <= W'(RST_SOURCE_WIDTH);
			src_height_q <= W'(RST_SOURCE_HEIGHT);
			win_left_q   <= W'(RST_WINDOW_LEFT);
			win_top_q    <= W'(RST_WINDOW_TOP);
			win_size_q   <= W'(RST_WINDOW_SIZE);
			out_size_q   <= W'(RST_OUTPUT_SIZE);
			start_q      <= 1'b1;
		end else begin
			start_q <= cfg_we;
			if (cfg_we) begin
				unique case (cfg_index)
					REG_SOURCE_WIDTH:  src_width_q  <= cfg_data;
					REG_SOURCE_HEIGHT: src_height_q <= cfg_data;
					REG_WINDOW_LEFT:   win_left_q   <= cfg_data;
					REG_WINDOW_TOP:    win_top_q    <= cfg_data;
					REG_WINDOW_SIZE:   win_size_q   <= cfg_data;
					REG_OUTPUT_SIZE:   out_size_q   <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	assign dsize = (out_size_q < win_size_q) ? out_size_q : win_size_q;

	csrgb_div #(.W(W)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start_q),
		.busy      (div_busy),
		.dividend  (win_size_q),
		.divisor   (dsize),
		.quotient  (step_q),
		.remainder (step_r)
	);

	assign busy     = start_q | div_busy;
	assign out_free = !valid_q || !out_stall;
	assign s1_go    = valid_s1 && out_free;
	assign in_stall = busy || (valid_s1 && !out_free);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_go || !valid_s1) begin
			valid_s1 <= in_valid && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			pixel_s1 <= pixel;
			fs_s1    <= frame_start;
		end
	end

	always_comb begin
		e_src_col  = fs_s1 ? '0 : src_col_q;
		e_src_row  = fs_s1 ? '0 : src_row_q;
		e_out_col  = fs_s1 ? '0 : out_col_q;
		e_out_row  = fs_s1 ? '0 : out_row_q;
		e_col_axis = fs_s1 ? '0 : col_axis_q;
		e_row_axis = fs_s1 ? '0 : row_axis_q;

		row_hit = (dsize != '0) && (e_out_row < dsize) && (e_src_row >= win_top_q) &&
			((e_src_row - win_top_q) == e_row_axis.off);
		col_hit = (dsize != '0) && (e_out_col < dsize) && (e_src_col >= win_left_q) &&
			((e_src_col - win_left_q) == e_col_axis.off);
		hit = row_hit && col_hit;
		le  = (e_out_col == dsize - 1'b1);
		fe  = le && (e_out_row == dsize - 1'b1);

		n_src_col  = e_src_col;
		n_src_row  = e_src_row;
		n_out_col  = e_out_col;
		n_out_row  = e_out_row;
		n_col_axis = e_col_axis;
		n_row_axis = e_row_axis;

		if (hit) begin
			n_col_axis = advance(e_col_axis, step_q, step_r, dsize);
			n_out_col  = e_out_col + 1'b1;
		end

		if (e_src_col == src_width_q - 1'b1) begin
			n_src_col  = '0;
			n_out_col  = '0;
			n_col_axis = '0;
			if (row_hit) begin
				n_row_axis = advance(e_row_axis, step_q, step_r, dsize);
				n_out_row  = e_out_row + 1'b1;
			end
			if (e_src_row == src_height_q - 1'b1) begin
				n_src_row  = '0;
				n_out_row  = '0;
				n_row_axis = '0;
			end else begin
				n_src_row = e_src_row + 1'b1;
			end
		end else begin
			n_src_col = e_src_col + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_col_q  <= '0;
			src_row_q  <= '0;
			out_col_q  <= '0;
			out_row_q  <= '0;
			col_axis_q <= '0;
			row_axis_q <= '0;
		end else if (s1_go) begin
			src_col_q  <= n_src_col;
			src_row_q  <= n_src_row;
			out_col_q  <= n_out_col;
			out_row_q  <= n_out_row;
			col_axis_q <= n_col_axis;
			row_axis_q <= n_row_axis;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (out_free) begin
			valid_q <= s1_go && hit;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && hit) begin
			red       <= {pixel_s1[15:11] & 5'(RED_MASK), 3'b000};
			green     <= {pixel_s1[10:5] & 6'(GREEN_MASK), 2'b00};
			blue      <= {pixel_s1[4:0] & 5'(RED_MASK), 3'b000};
			line_end  <= le;
			frame_end <= fe;
		end
	end

	assign out_valid = valid_q;

endmodule

### tb/tb.sv
// Self-checking testbench for the crop, downscale and RGB565-to-RGB888 block.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import csrgb_pkg::*;

	typedef logic [COORD_BITS_DEF-1:0] coord_t;
	typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       line_end;
		logic       frame_end;
	} rgb_out_t;

	typedef struct packed {
		coord_t src_w;
		coord_t src_h;
		coord_t left;
		coord_t top;
		coord_t size;
		coord_t out_size;
	} window_cfg_t;

	typedef struct packed {
		logic [15:0] pix;
		logic        fs;
		logic        typed;
		rgb_out_t    res;
	} pixel_row_t;

	typedef struct {
		window_cfg_t win;
		int          items;
		bit          squeeze;
	} corner_phase_t;

	localparam cfg_index_t REG_SPARE_LO = 3'd6;
	localparam cfg_index_t REG_SPARE_HI = 3'd7;
	localparam rgb_out_t   NO_RGB = '0;
	localparam int         HOLD_CYCLES = 300;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [15:0] pixel = '0;
	logic       frame_start = 1'b0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	logic       line_end;
	logic       frame_end;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	cfg_index_t cfg_index = '0;
	coord_t     cfg_data = '0;

	crop_scale_rgb565_to_rgb888 uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.pixel(pixel),
		.frame_start(frame_start),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.red(red),
		.green(green),
		.blue(blue),
		.line_end(line_end),
		.frame_end(frame_end),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	// register copies
	coord_t cfg_src_w = coord_t'(RST_SOURCE_WIDTH);
	coord_t cfg_src_h = coord_t'(RST_SOURCE_HEIGHT);
	coord_t cfg_left = coord_t'(RST_WINDOW_LEFT);
	coord_t cfg_top = coord_t'(RST_WINDOW_TOP);
	coord_t cfg_size = coord_t'(RST_WINDOW_SIZE);
	coord_t cfg_out = coord_t'(RST_OUTPUT_SIZE);

	// raster position and selection accumulators
	coord_t src_x = '0;
	coord_t src_y = '0;
	coord_t dst_x = '0;
	coord_t dst_y = '0;
	coord_t x_offset = '0;
	coord_t x_rem = '0;
	coord_t y_offset = '0;
	coord_t y_rem = '0;

	rgb_out_t pending_rgb[$];
	rgb_out_t want;
	int       errors = 0;
	bit       no_idle = 1'b0;
	int       squeeze_requests = 0;
	int       squeeze_served = 0;
	int       hold_left = 0;

	pixel_row_t directed_rows [20] = '{
		'{16'hFFFF, 1'b1, 1'b1, '{8'hF8, 8'hFC, 8'hF8, 1'b0, 1'b0}},
		'{16'h1234, 1'b0, 1'b0, NO_RGB},
		'{16'h0000, 1'b0, 1'b1, '{8'h00, 8'h00, 8'h00, 1'b1, 1'b0}},
		'{16'hAAAA, 1'b0, 1'b0, NO_RGB},
		'{16'h5A5A, 1'b0, 1'b0, NO_RGB},
		'{16'hFFFF, 1'b0, 1'b0, NO_RGB},
		'{16'h0000, 1'b0, 1'b0, NO_RGB},
		'{16'hC3C3, 1'b0, 1'b0, NO_RGB},
		'{16'hF800, 1'b0, 1'b1, '{8'hF8, 8'h00, 8'h00, 1'b0, 1'b0}},
		'{16'h5555, 1'b0, 1'b0, NO_RGB},
		'{16'h07E0, 1'b0, 1'b1, '{8'h00, 8'hFC, 8'h00, 1'b1, 1'b1}},
		'{16'h0001, 1'b0, 1'b0, NO_RGB},
		'{16'h8001, 1'b0, 1'b0, NO_RGB},
		'{16'h7FFE, 1'b0, 1'b0, NO_RGB},
		'{16'h0F0F, 1'b0, 1'b0, NO_RGB},
		'{16'hF0F0, 1'b0, 1'b0, NO_RGB},
		'{16'h001F, 1'b0, 1'b1, '{8'h00, 8'h00, 8'hF8, 1'b0, 1'b0}},
		'{16'h1234, 1'b0, 1'b0, NO_RGB},
		'{16'h8410, 1'b1, 1'b1, '{8'h80, 8'h80, 8'h80, 1'b0, 1'b0}},
		'{16'h7BEF, 1'b0, 1'b0, NO_RGB}
	};

	corner_phase_t corner_phases [7] = '{
		'{'{12'd20, 12'd3, 12'd18, 12'd1, 12'd4095, 12'd1}, 80, 1'b0},
		'{'{12'd6, 12'd6, 12'd1, 12'd1, 12'd4095, 12'd4095}, 200, 1'b1},
		'{'{12'd5, 12'd5, 12'd4095, 12'd4095, 12'd1, 12'd1}, 100, 1'b0},
		'{'{12'd4, 12'd4, 12'd0, 12'd0, 12'd0, 12'd3}, 60, 1'b0},
		'{'{12'd4, 12'd4, 12'd0, 12'd0, 12'd3, 12'd0}, 60, 1'b0},
		'{'{12'd0, 12'd1, 12'd2, 12'd0, 12'd2, 12'd2}, 60, 1'b0},
		'{'{12'd3, 12'd0, 12'd1, 12'd2, 12'd2, 12'd2}, 60, 1'b0}
	};

	function automatic void step_axis(inout coord_t ofs, inout coord_t rem, input coord_t d);
		int unsigned q;
		int unsigned r;
		int unsigned nr;
		int unsigned no;
		q = cfg_size / d;
		r = cfg_size % d;
		nr = rem + r;
		no = ofs + q;
		if (nr >= d) begin
			nr -= d;
			no++;
		end
		ofs = coord_t'(no);
		rem = coord_t'(nr);
	endfunction

	function automatic void clear_columns();
		dst_x = '0;
		x_offset = '0;
		x_rem = '0;
	endfunction

	function automatic void clear_rows();
		dst_y = '0;
		y_offset = '0;
		y_rem = '0;
	endfunction

	function automatic bit select_pixel(input logic [15:0] p, input logic fs,
			output rgb_out_t res);
		coord_t d;
		bit row_hit;
		bit col_hit;
		res = NO_RGB;
		if (fs) begin
			src_x = '0;
			src_y = '0;
			clear_columns();
			clear_rows();
		end
		d = (cfg_out < cfg_size) ? cfg_out : cfg_size;
		row_hit = d != 0 && dst_y < d && src_y >= cfg_top &&
			coord_t'(src_y - cfg_top) == y_offset;
		col_hit = d != 0 && dst_x < d && src_x >= cfg_left &&
			coord_t'(src_x - cfg_left) == x_offset;
		if (row_hit && col_hit) begin
			res.red = {p[15:11], 3'b000};
			res.green = {p[10:5], 2'b00};
			res.blue = {p[4:0], 3'b000};
			res.line_end = dst_x == coord_t'(d - 1'b1);
			res.frame_end = res.line_end && dst_y == coord_t'(d - 1'b1);
			step_axis(x_offset, x_rem, d);
			dst_x = dst_x + 1'b1;
		end
		if (src_x == coord_t'(cfg_src_w - 1'b1)) begin
			src_x = '0;
			clear_columns();
			if (row_hit) begin
				step_axis(y_offset, y_rem, d);
				dst_y = dst_y + 1'b1;
			end
			if (src_y == coord_t'(cfg_src_h - 1'b1)) begin
				src_y = '0;
				clear_rows();
			end else begin
				src_y = src_y + 1'b1;
			end
		end else begin
			src_x = src_x + 1'b1;
		end
		return row_hit && col_hit;
	endfunction

	task automatic send_pixel(input logic [15:0] p, input logic fs, output bit hit,
			output rgb_out_t res);
		while (!no_idle && $urandom_range(99) < 18) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		pixel <= p;
		frame_start <= fs;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		hit = select_pixel(p, fs, res);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_rgb.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_index_t idx, input coord_t val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			REG_SOURCE_WIDTH: cfg_src_w = val;
			REG_SOURCE_HEIGHT: cfg_src_h = val;
			REG_WINDOW_LEFT: cfg_left = val;
			REG_WINDOW_TOP: cfg_top = val;
			REG_WINDOW_SIZE: cfg_size = val;
			REG_OUTPUT_SIZE: cfg_out = val;
			default: ;
		endcase
	endtask

	task automatic program_window(input window_cfg_t c);
		wait_idle();
		write_reg(REG_SOURCE_WIDTH, c.src_w);
		write_reg(REG_SOURCE_HEIGHT, c.src_h);
		write_reg(REG_WINDOW_LEFT, c.left);
		write_reg(REG_WINDOW_TOP, c.top);
		write_reg(REG_WINDOW_SIZE, c.size);
		write_reg(REG_OUTPUT_SIZE, c.out_size);
		write_reg($urandom_range(1) ? REG_SPARE_LO : REG_SPARE_HI, coord_t'($urandom));
		cfg_valid <= 1'b0;
	endtask

	task automatic run_pixels(input int n);
		int unsigned frame_len;
		int unsigned pos;
		logic fs;
		bit hit;
		rgb_out_t res;
		frame_len = (cfg_src_w == 0 ? (1 << COORD_BITS_DEF) : int'(cfg_src_w)) *
			(cfg_src_h == 0 ? (1 << COORD_BITS_DEF) : int'(cfg_src_h));
		pos = 0;
		for (int i = 0; i < n; i++) begin
			if (i == 0)
				fs = 1'b1;
			else if (pos == 0)
				fs = $urandom_range(3) != 0;
			else
				fs = $urandom_range(99) < 3;
			if (fs)
				pos = 0;
			send_pixel(16'($urandom), fs, hit, res);
			if (hit)
				pending_rgb.push_back(res);
			pos = (pos + 1) % frame_len;
		end
	endtask

	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (squeeze_served != squeeze_requests) begin
			squeeze_served++;
			hold_left = HOLD_CYCLES;
			out_stall <= 1'b1;
		end else begin
			out_stall <= !no_idle && ($urandom_range(99) < 18);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_rgb.size() == 0) begin
				$display("%0t: unexpected transfer, expected none, got %0h %0h %0h %0b %0b",
					$time, red, green, blue, line_end, frame_end);
				errors++;
			end else begin
				want = pending_rgb.pop_front();
				if (red !== want.red) begin
					$display("%0t: red expected %0h got %0h", $time, want.red, red);
					errors++;
				end
				if (green !== want.green) begin
					$display("%0t: green expected %0h got %0h", $time, want.green, green);
					errors++;
				end
				if (blue !== want.blue) begin
					$display("%0t: blue expected %0h got %0h", $time, want.blue, blue);
					errors++;
				end
				if (line_end !== want.line_end) begin
					$display("%0t: line_end expected %0b got %0b", $time, want.line_end,
						line_end);
					errors++;
				end
				if (frame_end !== want.frame_end) begin
					$display("%0t: frame_end expected %0b got %0b", $time, want.frame_end,
						frame_end);
					errors++;
				end
			end
		end
	end

	initial begin : stimulus
		window_cfg_t c;
		bit hit;
		rgb_out_t res;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		run_pixels(200);

		program_window('{12'd4, 12'd4, 12'd0, 12'd0, 12'd4, 12'd2});
		foreach (directed_rows[i]) begin
			send_pixel(directed_rows[i].pix, directed_rows[i].fs, hit, res);
			if (directed_rows[i].typed)
				pending_rgb.push_back(directed_rows[i].res);
			else if (hit)
				pending_rgb.push_back(res);
		end

		for (int k = 0; k < 12; k++) begin
			c.src_w = coord_t'($urandom_range(1, 12));
			c.src_h = coord_t'($urandom_range(1, 10));
			c.left = coord_t'($urandom_range(0, c.src_w));
			c.top = coord_t'($urandom_range(0, c.src_h));
			c.size = coord_t'($urandom_range(1, 12));
			c.out_size = coord_t'($urandom_range(1, 14));
			program_window(c);
			no_idle = k == 6;
			run_pixels(60);
			no_idle = 1'b0;
		end

		foreach (corner_phases[i]) begin
			program_window(corner_phases[i].win);
			if (corner_phases[i].squeeze)
				squeeze_requests++;
			run_pixels(corner_phases[i].items);
		end

		wait_idle();
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("tb: done, errors");
		$finish;
	end

endmodule
